// File: rtl/mppo_pkg.sv
package mppo_pkg;

  // Field widths.
  localparam int unsigned ADC_W      = 10;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned OFFS_W     = 16;
  localparam int unsigned AVG_W      = 16;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned VLIM_W     = 10;
  localparam int unsigned POWER_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Averaging filter: avg += (x - avg) >>> AVG_SHIFT.
  localparam int unsigned AVG_SHIFT = 4;

  // Over-voltage test: duty * (vout_limit * 21 + volt_avg) >= vout_limit * 3360.
  localparam logic [4:0]  VLIM_SCALE = 5'd21;
  localparam logic [11:0] VLIM_BOUND = 12'd3360;
  localparam int unsigned K_W        = 17;
  localparam int unsigned RHS_W      = 22;
  localparam int unsigned LHS_W      = 25;

  // The protection loop takes at most this many duty steps.
  localparam int unsigned PROT_MAX_ITER = 256;
  localparam int unsigned ITER_W        = 9;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLT_GAIN   = 3'd0,
    CFG_VOLT_OFFSET = 3'd1,
    CFG_CURR_GAIN   = 3'd2,
    CFG_CURR_OFFSET = 3'd3,
    CFG_DUTY_MIN    = 3'd4,
    CFG_DUTY_MAX    = 3'd5,
    CFG_DUTY_STEP   = 3'd6,
    CFG_VOUT_LIMIT  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        [GAIN_W-1:0] volt_gain;
    logic signed [OFFS_W-1:0] volt_offset;
    logic        [GAIN_W-1:0] curr_gain;
    logic signed [OFFS_W-1:0] curr_offset;
    logic        [DUTY_W-1:0] duty_min;
    logic        [DUTY_W-1:0] duty_max;
    logic        [DUTY_W-1:0] duty_step;
    logic        [VLIM_W-1:0] vout_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    volt_gain:   8'd1,
    volt_offset: 16'sd0,
    curr_gain:   8'd1,
    curr_offset: 16'sd0,
    duty_min:    8'd10,
    duty_max:    8'd150,
    duty_step:   8'd1,
    vout_limit:  10'd60
  };

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_SCALE,
    OP_SAT,
    OP_AVG,
    OP_POWER,
    OP_LIMITS,
    OP_PERTURB,
    OP_PROT_MUL,
    OP_PROT_STEP,
    OP_COMMIT
  } mppo_op_e;

  // How the step counter moves on.
  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_DISPATCH,
    BR_LOOP,
    BR_OUT
  } mppo_br_e;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_MUL_SCALE = 4'd1;
  localparam step_t STEP_SAT       = 4'd2;
  localparam step_t STEP_AVG       = 4'd3;
  localparam step_t STEP_POWER     = 4'd4;
  localparam step_t STEP_LIMITS    = 4'd5;
  localparam step_t STEP_PERTURB   = 4'd6;
  localparam step_t STEP_PROT_MUL  = 4'd7;
  localparam step_t STEP_PROT_STEP = 4'd8;
  localparam step_t STEP_COMMIT    = 4'd9;

  typedef struct packed {
    mppo_op_e op;
    mppo_br_e br;
    step_t    target;
  } ctrl_t;

  // Status that the datapath hands back to the sequencer and output stage.
  typedef struct packed {
    logic               prot_go;
    logic [DUTY_W-1:0]  duty;
    logic [POWER_W-1:0] power;
  } stat_t;

  // Microprogram. The idle step dispatches: a sample falls through to the
  // next step, a tick jumps to the target.
  function automatic ctrl_t mppo_rom(step_t s);
    ctrl_t c;
    c = '{op: OP_NONE, br: BR_JUMP, target: STEP_IDLE};
    case (s)
      STEP_IDLE:      c = '{op: OP_NONE,      br: BR_DISPATCH, target: STEP_POWER};
      STEP_MUL_SCALE: c = '{op: OP_MUL_SCALE, br: BR_NEXT,     target: STEP_IDLE};
      STEP_SAT:       c = '{op: OP_SAT,       br: BR_NEXT,     target: STEP_IDLE};
      STEP_AVG:       c = '{op: OP_AVG,       br: BR_JUMP,     target: STEP_IDLE};
      STEP_POWER:     c = '{op: OP_POWER,     br: BR_NEXT,     target: STEP_IDLE};
      STEP_LIMITS:    c = '{op: OP_LIMITS,    br: BR_NEXT,     target: STEP_IDLE};
      STEP_PERTURB:   c = '{op: OP_PERTURB,   br: BR_NEXT,     target: STEP_IDLE};
      STEP_PROT_MUL:  c = '{op: OP_PROT_MUL,  br: BR_NEXT,     target: STEP_IDLE};
      STEP_PROT_STEP: c = '{op: OP_PROT_STEP, br: BR_LOOP,     target: STEP_PROT_MUL};
      STEP_COMMIT:    c = '{op: OP_COMMIT,    br: BR_OUT,      target: STEP_IDLE};
      default:        c = '{op: OP_NONE,      br: BR_JUMP,     target: STEP_IDLE};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mppo_if.sv
interface mppo_in_if import mppo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [ADC_W-1:0] adc_sample;

  modport source (output valid, output op, output adc_sample, input ready);
  modport sink   (input valid, input op, input adc_sample, output ready);
endinterface

interface mppo_out_if import mppo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty;
  logic [POWER_W-1:0] power;

  modport source (output valid, output duty, output power, input ready);
  modport sink   (input valid, input duty, input power, output ready);
endinterface

// File: rtl/mppo_datapath.sv
module mppo_datapath import mppo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mppo_op_e         op_i,
  input  cfg_t             cfg_i,
  input  logic [ADC_W-1:0] sample_i,
  output stat_t            stat_o
);

  // Architectural state.
  logic               chan_q;
  logic [AVG_W-1:0]   volt_avg_q, curr_avg_q;
  logic [DUTY_W-1:0]  duty_now_q;
  logic               dir_up_q;
  logic [POWER_W-1:0] last_power_q;

  // Working registers of the current transaction.
  logic [ADC_W+GAIN_W-1:0] prod_q;
  logic [AVG_W-1:0]        x_q;
  logic [POWER_W-1:0]      power_q;
  logic [K_W-1:0]          k_q;
  logic [RHS_W-1:0]        rhs_q;
  logic [LHS_W-1:0]        lhs_q;
  logic [DUTY_W-1:0]       d_q;
  logic [ITER_W-1:0]       iter_q;

  logic [GAIN_W-1:0]        gain;
  logic signed [OFFS_W-1:0] offs;
  logic signed [19:0]       scaled;
  logic [AVG_W-1:0]         x_sat;
  logic [AVG_W-1:0]         avg_cur;
  logic signed [AVG_W:0]    diff;
  logic signed [AVG_W:0]    adj;
  logic [AVG_W-1:0]         avg_new;
  logic                     flip;
  logic                     dir_new;
  logic                     prot_go;

  assign gain = chan_q ? cfg_i.curr_gain : cfg_i.volt_gain;
  assign offs = chan_q ? cfg_i.curr_offset : cfg_i.volt_offset;

  // Scaled sample spans -32768 to 293632, so 20 signed bits hold it.
  assign scaled = $signed({2'b00, prod_q}) + $signed({{4{offs[OFFS_W-1]}}, offs});

  always_comb begin
    if (scaled[19]) begin
      x_sat = '0;
    end else if (|scaled[18:16]) begin
      x_sat = '1;
    end else begin
      x_sat = scaled[15:0];
    end
  end

  // Both branches of the filter round toward minus infinity, which is
  // exactly an arithmetic shift of the difference.
  assign avg_cur = chan_q ? curr_avg_q : volt_avg_q;
  assign diff    = $signed({1'b0, x_q}) - $signed({1'b0, avg_cur});
  assign adj     = diff >>> AVG_SHIFT;
  assign avg_new = avg_cur + adj[AVG_W-1:0];

  assign flip    = (duty_now_q > cfg_i.duty_max) || (duty_now_q < cfg_i.duty_min) ||
                   (power_q < last_power_q);
  assign dir_new = dir_up_q ^ flip;

  assign prot_go = (LHS_W'(rhs_q) <= lhs_q) &&
                   (d_q > cfg_i.duty_min) && (d_q < cfg_i.duty_max) &&
                   (iter_q < ITER_W'(PROT_MAX_ITER));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q       <= 1'b0;
      volt_avg_q   <= '0;
      curr_avg_q   <= '0;
      duty_now_q   <= DUTY_RESET;
      dir_up_q     <= 1'b0;
      last_power_q <= '0;
    end else begin
      case (op_i)
        OP_AVG: begin
          if (chan_q) begin
            curr_avg_q <= avg_new;
          end else begin
            volt_avg_q <= avg_new;
          end
          chan_q <= ~chan_q;
        end
        OP_PERTURB: begin
          dir_up_q <= dir_new;
        end
        OP_COMMIT: begin
          duty_now_q   <= d_q;
          last_power_q <= power_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_MUL_SCALE: prod_q <= (ADC_W+GAIN_W)'(sample_i) * (ADC_W+GAIN_W)'(gain);
      OP_SAT:       x_q    <= x_sat;
      OP_POWER:     power_q <= POWER_W'(volt_avg_q) * POWER_W'(curr_avg_q);
      OP_LIMITS: begin
        k_q   <= K_W'(cfg_i.vout_limit) * K_W'(VLIM_SCALE) + K_W'(volt_avg_q);
        rhs_q <= RHS_W'(cfg_i.vout_limit) * RHS_W'(VLIM_BOUND);
      end
      OP_PERTURB: begin
        d_q    <= dir_new ? duty_now_q + cfg_i.duty_step : duty_now_q - cfg_i.duty_step;
        iter_q <= '0;
      end
      OP_PROT_MUL:  lhs_q <= LHS_W'(d_q) * LHS_W'(k_q);
      OP_PROT_STEP: begin
        if (prot_go) begin
          d_q    <= d_q - cfg_i.duty_step;
          iter_q <= iter_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign stat_o = '{prot_go: prot_go, duty: d_q, power: power_q};

endmodule

// File: rtl/mppt_perturb_observe.sv
// Channel   Dir  Payload                          Handshake
// in_ch_i   in   op (1b), adc_sample (10b)        valid / ready
// out_ch_o  out  duty (8b), power (32b)           valid / ready
// cfg       in   cfg_idx_i (3b), cfg_data_i (16b) cfg_we_i, no back-pressure
//
// An ADC sample transaction runs dispatch, scale multiply, offset and
// saturate, filter update. A control tick runs dispatch, power, limits,
// perturb, N (0 to 256) over-voltage duty steps and commit; each step is
// one multiply and one compare of the shared protection datapath.
// Reset at once clears the sequencer and filters and presets the duty to 80.
// A result waits in the output register; the sequencer only stalls at the
// commit step when that register still holds an untaken result.

module mppt_perturb_observe import mppo_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mppo_in_if.sink               in_ch_i,
  mppo_out_if.source            out_ch_o
);

  cfg_t  cfg_q;
  step_t step_q, step_d;
  ctrl_t ctrl;
  mppo_op_e dp_op;
  stat_t stat;

  logic [ADC_W-1:0]   sample_q;
  logic               out_valid_q, out_valid_d;
  logic [DUTY_W-1:0]  out_duty_q;
  logic [POWER_W-1:0] out_power_q;
  logic               out_stall;
  logic               in_take;
  logic               commit_go;

  // Configuration registers. User must write only while idle (unchecked).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VOLT_GAIN:   cfg_q.volt_gain   <= cfg_data_i[GAIN_W-1:0];
        CFG_VOLT_OFFSET: cfg_q.volt_offset <= $signed(cfg_data_i);
        CFG_CURR_GAIN:   cfg_q.curr_gain   <= cfg_data_i[GAIN_W-1:0];
        CFG_CURR_OFFSET: cfg_q.curr_offset <= $signed(cfg_data_i);
        CFG_DUTY_MIN:    cfg_q.duty_min    <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_MAX:    cfg_q.duty_max    <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_STEP:   cfg_q.duty_step   <= cfg_data_i[DUTY_W-1:0];
        CFG_VOUT_LIMIT:  cfg_q.vout_limit  <= cfg_data_i[VLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The control word of the current step comes straight from the program.
  assign ctrl      = mppo_rom(step_q);
  assign out_stall = out_valid_q && !out_ch_o.ready;

  // Next step.
  always_comb begin
    step_d = step_q;
    case (ctrl.br)
      BR_NEXT: step_d = step_t'(step_q + 1'b1);
      BR_JUMP: step_d = ctrl.target;
      BR_DISPATCH: begin
        if (in_ch_i.valid) begin
          step_d = in_ch_i.op ? ctrl.target : step_t'(step_q + 1'b1);
        end
      end
      BR_LOOP: step_d = stat.prot_go ? ctrl.target : step_t'(step_q + 1'b1);
      BR_OUT: begin
        if (!out_stall) begin
          step_d = ctrl.target;
        end
      end
      default: step_d = STEP_IDLE;
    endcase
  end

  // Sequencer outputs. A stalled commit issues no datapath operation, so
  // the duty and power state update once, together with the output load.
  always_comb begin
    in_take = (ctrl.br == BR_DISPATCH);
    dp_op   = ctrl.op;
    if (ctrl.br == BR_OUT && out_stall) begin
      dp_op = OP_NONE;
    end
  end

  assign commit_go      = (dp_op == OP_COMMIT);
  assign in_ch_i.ready  = in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // The raw sample is held for the scale multiply of the next cycle.
  always_ff @(posedge clk_i) begin
    if (in_take && in_ch_i.valid) begin
      sample_q <= in_ch_i.adc_sample;
    end
  end

  mppo_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (dp_op),
    .cfg_i    (cfg_q),
    .sample_i (sample_q),
    .stat_o   (stat)
  );

  // Output register: one result of a tick waits here until taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit_go) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      out_duty_q  <= stat.duty;
      out_power_q <= stat.power;
    end
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.duty  = out_duty_q;
  assign out_ch_o.power = out_power_q;

  // A commit that is not held back always presents a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_COMMIT && !out_stall) |=> out_ch_o.valid)
    else $error("commit did not present a result");

  // A commit never overwrites a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_COMMIT && out_stall) |=> (step_q == STEP_COMMIT))
    else $error("commit advanced over a pending result");

  // A tick transaction starts the power step right after dispatch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready && in_ch_i.op) |=> (step_q == STEP_POWER))
    else $error("tick not dispatched to the power step");

  // Leaving the protection loop always goes to the commit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_PROT_STEP && !stat.prot_go) |=> (step_q == STEP_COMMIT))
    else $error("protection loop exit missed the commit step");

endmodule
